// ===== hw/rtl/upd_pkg.sv =====
// Shared types, constants and character helpers for the URL percent decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    // Each hex digit carries log2(16) bits of the decoded byte.
    localparam int HEX_BASE = 16;
    localparam int HEX_BITS = $clog2(HEX_BASE);

    // Depth of the queue between the classifier and the byte sequencer.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // What is held from earlier characters of an escape.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } t_pend;

    // One classified input word: up to three bytes to emit, in order.
    typedef struct packed {
        logic [1:0] cnt;
        logic       eos;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_op;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [HEX_BITS-1:0] hex_val(input logic [7:0] c);
        logic [HEX_BITS-1:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[HEX_BITS-1:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[HEX_BITS-1:0] + HEX_BITS'(9);
        end else begin
            v = '0;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/url_percent_decoder.sv =====
// Top level of the URL percent decoder: classifier, record queue, byte
// sequencer. Depends on upd_pkg, upd_front, upd_fifo, upd_back.
//
//   channel  | handshake      | word
//   ---------+----------------+-------------------------------------------
//   input    | i_push, o_full | i_char_in[7:0], i_string_end
//   result   | o_empty, i_pop | o_byte_out[7:0], o_run_last, o_string_done
//
// One character is accepted per cycle while o_full is low; the output sequencer
// emits the bytes it yields one per cycle while results are popped, so a broken
// escape yields up to three bytes. Results pass the queue, then the output reg.
// A four-entry record queue lets the input keep going while results stall.
// Synchronous active-low reset empties the queue and drops any held escape.
`timescale 1ns / 1ps

module url_percent_decoder import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_char_in,
    input  logic       i_string_end,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_byte_out,
    output logic       o_run_last,
    output logic       o_string_done
);

    logic         accept;
    logic         f_push;
    t_op          f_op;
    t_pend        f_pend;
    t_op          q_op;
    logic         q_empty, q_pop;
    logic [QAW:0] q_count;

    assign accept = i_push && !o_full;

    upd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_in    (i_char_in),
        .i_string_end (i_string_end),
        .o_push       (f_push),
        .o_op         (f_op),
        .o_pend       (f_pend)
    );

    upd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_op    (f_op),
        .i_pop   (q_pop),
        .o_op    (q_op),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    upd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (q_op),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_byte_out    (o_byte_out),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_string_done) |-> o_run_last)
        else $error("string_done without run_last");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_string_end) |=> (f_pend == PEND_NONE))
        else $error("escape still held after string end");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (QAW+1)'(QDEPTH))
        else $error("record queue overflow");

    a_q_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_empty && o_empty) |=> !o_empty)
        else $error("output register not refilled from queue");

endmodule

// ===== hw/rtl/upd_front.sv =====
// Front end: tracks the pending escape and classifies each accepted character
// into a record of zero to three output bytes. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_front import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_in,
    input  logic       i_string_end,
    output logic       o_push,
    output t_op        o_op,
    output t_pend      o_pend
);

    t_pend      r_pend, n_pend;
    logic [7:0] r_digit;
    logic       hx;
    logic       pct;

    assign hx  = is_hex(i_char_in);
    // A '%' on the last character cannot open an escape.
    assign pct = (i_char_in == PCT_CHAR) && !i_string_end;

    always_comb begin
        case (r_pend)
            PEND_NONE:  n_pend = pct ? PEND_PCT : PEND_NONE;
            PEND_PCT: begin
                if (hx && !i_string_end)
                    n_pend = PEND_DIGIT;
                else if (!hx && pct)
                    n_pend = PEND_PCT;
                else
                    n_pend = PEND_NONE;
            end
            PEND_DIGIT: n_pend = (!hx && pct) ? PEND_PCT : PEND_NONE;
            default:    n_pend = pct ? PEND_PCT : PEND_NONE;
        endcase
    end

    always_comb begin
        o_op     = '0;
        o_op.eos = i_string_end;
        case (r_pend)
            PEND_PCT: begin
                if (hx && !i_string_end) begin
                    o_op.cnt = 2'd0;
                end else if (hx) begin
                    o_op.cnt = 2'd2;
                    o_op.b0  = PCT_CHAR;
                    o_op.b1  = i_char_in;
                end else begin
                    // broken escape: literal '%', then the character afresh
                    o_op.b0  = PCT_CHAR;
                    o_op.b1  = i_char_in;
                    o_op.cnt = pct ? 2'd1 : 2'd2;
                end
            end
            PEND_DIGIT: begin
                if (hx) begin
                    o_op.cnt = 2'd1;
                    o_op.b0  = {hex_val(r_digit), hex_val(i_char_in)};
                end else begin
                    o_op.b0  = PCT_CHAR;
                    o_op.b1  = r_digit;
                    o_op.b2  = i_char_in;
                    o_op.cnt = pct ? 2'd2 : 2'd3;
                end
            end
            default: begin
                o_op.b0  = i_char_in;
                o_op.cnt = pct ? 2'd0 : 2'd1;
            end
        endcase
    end

    assign o_push = i_accept && (o_op.cnt != 2'd0);
    assign o_pend = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
        end else if (i_accept) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_pend == PEND_PCT && hx && !i_string_end) begin
            r_digit <= i_char_in;
        end
    end

endmodule

// ===== hw/rtl/upd_fifo.sv =====
// Short record queue between the classifier and the byte sequencer.
// Depends on upd_pkg for the record type and depth.
`timescale 1ns / 1ps

module upd_fifo import upd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_op          i_op,
    input  logic         i_pop,
    output t_op          o_op,
    output logic         o_full,
    output logic         o_empty,
    output logic [QAW:0] o_count
);

    t_op          r_slot [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_op    = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

endmodule

// ===== hw/rtl/upd_back.sv =====
// Back end: walks the bytes of the head record into the output register, one per
// cycle while that register is empty or being popped. Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_back import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_byte_out,
    output logic       o_run_last,
    output logic       o_string_done
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_run_last, r_done;
    logic       load, last;
    logic [7:0] cur;

    always_comb begin
        case (r_idx)
            2'd0:    cur = i_op.b0;
            2'd1:    cur = i_op.b1;
            default: cur = i_op.b2;
        endcase
    end

    assign last    = ((r_idx + 2'd1) == i_op.cnt);
    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= cur;
            r_run_last <= last;
            r_done     <= last && i_op.eos;
        end
    end

    assign o_empty       = !r_valid;
    assign o_byte_out    = r_byte;
    assign o_run_last    = r_run_last;
    assign o_string_done = r_done;

endmodule

// ===== tb/url_percent_decoder_tb.sv =====
// Self-checking testbench for url_percent_decoder: a directed table, then random strings.
// It predicts the decoded bytes and checks every popped word. Depends on upd_pkg and the DUT.
`timescale 1ns / 1ps

module url_percent_decoder_tb;
    import upd_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       done;
    } t_dec_word;

    // n < 0: expectation comes from the predictor
    typedef struct packed {
        logic [7:0] c;
        logic       e;
        int         n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_dir_row;

    localparam int NUM_DIR = 25;
    localparam int RAND_ITEMS = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_char_in = '0;
    logic       i_string_end = 1'b0;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_byte_out;
    logic       o_run_last;
    logic       o_string_done;

    url_percent_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_char_in     (i_char_in),
        .i_string_end  (i_string_end),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_byte_out    (o_byte_out),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_pend      esc_state = PEND_NONE;
    logic [7:0] held_digit = '0;
    logic [7:0] dec_bytes [3];
    int         dec_n;

    t_dec_word  pending_words [$];
    int         mismatches = 0;
    int         chars_sent = 0;
    int         words_seen = 0;
    int         strings_sent = 0;
    int         burst_left = 0;

    initial begin
        #2ms;
        $display("timeout: %0d words still expected", pending_words.size());
        $display("FAIL");
        $finish;
    end

    t_dir_row dir_rows [NUM_DIR] = '{
        '{8'h00, 1'b0,  1, 8'h00, 8'h00, 8'h00},   // zero byte passes through
        '{8'hFF, 1'b0,  1, 8'hFF, 8'h00, 8'h00},
        '{PCT_CHAR, 1'b0, 0, 8'h00, 8'h00, 8'h00},
        '{8'h66, 1'b0,  0, 8'h00, 8'h00, 8'h00},
        '{8'h46, 1'b0,  1, 8'hFF, 8'h00, 8'h00},   // %fF
        '{PCT_CHAR, 1'b0, 0, 8'h00, 8'h00, 8'h00},
        '{8'h30, 1'b0,  0, 8'h00, 8'h00, 8'h00},
        '{8'h30, 1'b0,  1, 8'h00, 8'h00, 8'h00},   // %00
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h67, 1'b0, -1, 8'h00, 8'h00, 8'h00},   // broken after '%'
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h41, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00}, // breaker restarts an escape
        '{8'h39, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h61, 1'b1, -1, 8'h00, 8'h00, 8'h00},
        '{PCT_CHAR, 1'b1, -1, 8'h00, 8'h00, 8'h00}, // lone '%' at end
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h42, 1'b1, -1, 8'h00, 8'h00, 8'h00},
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h37, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h7A, 1'b1,  3, PCT_CHAR, 8'h37, 8'h7A}, // three-word flush
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{PCT_CHAR, 1'b0, -1, 8'h00, 8'h00, 8'h00},
        '{8'h35, 1'b1, -1, 8'h00, 8'h00, 8'h00},
        '{8'h78, 1'b1, -1, 8'h00, 8'h00, 8'h00}
    };

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = 4'(c - 8'h30);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 4'(c - 8'h41 + 8'd10);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_digit_char(input logic [3:0] v, input logic upper);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + 8'(v);
        end else begin
            c = (upper ? 8'h41 : 8'h61) + 8'(v - 4'd10);
        end
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex_char(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function void emit_byte(input logic [7:0] b);
        if (dec_n < 3) begin
            dec_bytes[dec_n] = b;
            dec_n++;
        end
    endfunction

    function void take_plain(input logic [7:0] c, input logic e);
        if (c == PCT_CHAR && !e) begin
            esc_state = PEND_PCT;
        end else begin
            esc_state = PEND_NONE;
            emit_byte(c);
        end
    endfunction

    // advances the decoder state by one character, fills dec_bytes/dec_n
    function void decode_char(input logic [7:0] c, input logic e);
        dec_n = 0;
        case (esc_state)
            PEND_PCT: begin
                if (is_hex_char(c) && !e) begin
                    held_digit = c;
                    esc_state = PEND_DIGIT;
                end else if (is_hex_char(c)) begin
                    emit_byte(PCT_CHAR);
                    emit_byte(c);
                    esc_state = PEND_NONE;
                end else begin
                    emit_byte(PCT_CHAR);
                    take_plain(c, e);
                end
            end
            PEND_DIGIT: begin
                if (is_hex_char(c)) begin
                    emit_byte({nibble_of(held_digit), nibble_of(c)});
                    esc_state = PEND_NONE;
                end else begin
                    emit_byte(PCT_CHAR);
                    emit_byte(held_digit);
                    take_plain(c, e);
                end
            end
            default: take_plain(c, e);
        endcase
        if (e) esc_state = PEND_NONE;
    endfunction

    // drives one word, waits for it to be taken, then queues what it yields
    task automatic send_char(input logic [7:0] c, input logic e, input t_dir_row row);
        int k;
        int gap;
        t_dec_word w;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            // with no gap the push stays high straight into the next burst
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 8);
        end
        i_push <= 1'b1;
        i_char_in <= c;
        i_string_end <= e;
        do @(posedge i_clk); while (o_full);
        burst_left--;
        chars_sent++;
        decode_char(c, e);
        if (row.n >= 0) begin
            dec_n = row.n;
            dec_bytes[0] = row.b0;
            dec_bytes[1] = row.b1;
            dec_bytes[2] = row.b2;
        end
        for (k = 0; k < dec_n; k++) begin
            w.b = dec_bytes[k];
            w.last = (k == dec_n - 1);
            w.done = (k == dec_n - 1) && e;
            pending_words.push_back(w);
        end
    endtask

    // receiver: checks popped words, then picks the next pop value
    int rx_cycle = 0;
    always @(posedge i_clk) begin
        t_dec_word w;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                words_seen++;
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: byte=%02h last=%0b done=%0b",
                                 o_byte_out, o_run_last, o_string_done);
                end else begin
                    w = pending_words.pop_front();
                    if (o_byte_out !== w.b || o_run_last !== w.last ||
                        o_string_done !== w.done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %02h/%0b/%0b, got %02h/%0b/%0b",
                                     w.b, w.last, w.done, o_byte_out, o_run_last,
                                     o_string_done);
                    end
                end
            end
            rx_cycle++;
        end
        case ((rx_cycle / 64) % 3)
            0: i_pop <= 1'b1;
            1: i_pop <= 1'($urandom_range(0, 1));
            default: i_pop <= (rx_cycle % 5 == 0);
        endcase
    end

    initial begin
        int i;
        int pieces;
        int j;
        logic [7:0] str_chars [$];
        t_dir_row no_row;

        no_row = '{8'h00, 1'b0, -1, 8'h00, 8'h00, 8'h00};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < NUM_DIR; i++) begin
            send_char(dir_rows[i].c, dir_rows[i].e, dir_rows[i]);
        end

        // random strings: half the pieces well-formed escapes, the rest broken ones and noise
        while (chars_sent < NUM_DIR + RAND_ITEMS) begin
            str_chars.delete();
            pieces = $urandom_range(1, 6);
            for (j = 0; j < pieces; j++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        str_chars.push_back(PCT_CHAR);
                        str_chars.push_back(hex_digit_char(4'($urandom_range(0, 15)),
                                                           1'($urandom_range(0, 1))));
                        str_chars.push_back(hex_digit_char(4'($urandom_range(0, 15)),
                                                           1'($urandom_range(0, 1))));
                    end
                    5, 6: str_chars.push_back(8'($urandom_range(0, 255)));
                    7: begin
                        str_chars.push_back(PCT_CHAR);
                        if ($urandom_range(0, 1))
                            str_chars.push_back(hex_digit_char(4'($urandom_range(0, 15)),
                                                               1'($urandom_range(0, 1))));
                        str_chars.push_back(non_hex_char());
                    end
                    8: str_chars.push_back(PCT_CHAR);
                    default: begin
                        str_chars.push_back(PCT_CHAR);
                        str_chars.push_back(hex_digit_char(4'($urandom_range(0, 15)),
                                                           1'($urandom_range(0, 1))));
                    end
                endcase
            end
            for (j = 0; j < str_chars.size(); j++) begin
                send_char(str_chars[j], j == str_chars.size() - 1, no_row);
            end
            strings_sent++;
        end
        i_push <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d characters (%0d directed, %0d random strings)",
                 chars_sent, NUM_DIR, strings_sent);
        $display("checked %0d decoded words, %0d mismatches", words_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
